// ----- hdl/plc_pkg.sv -----
package plc_pkg;

  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 7;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH_RADIUS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SIZE = 2'd1;

  localparam logic [CFG_DATA_BITS-1:0] RADIUS_RESET = 7'd10;
  localparam logic [CFG_DATA_BITS-1:0] MIN_SIZE_RESET = 7'd20;

  localparam int COLOR_BITS = 3;
  localparam int COUNT_BITS = 16;
  localparam int DROP_BITS = 8;
  localparam int DEN_BITS = COUNT_BITS + 1;
  localparam int LIM_BITS = 22;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [DROP_BITS-1:0] DROP_MAX = 8'hFF;
  localparam logic [3:0] CM_TO_MM = 4'd10;

endpackage

// ----- hdl/plc_point_if.sv -----
interface plc_point_if import plc_pkg::*; #(parameter int COORD_BITS = 16);
  logic valid;
  logic ready;
  logic [COLOR_BITS-1:0] color_class;
  logic point_valid;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic frame_end;

  modport source(output valid, color_class, point_valid, pos_x, pos_y, pos_z, frame_end,
                 input ready);
  modport sink(input valid, color_class, point_valid, pos_x, pos_y, pos_z, frame_end,
               output ready);
endinterface

// ----- hdl/plc_record_if.sv -----
interface plc_record_if import plc_pkg::*; #(parameter int COORD_BITS = 16);
  logic valid;
  logic ready;
  logic [COLOR_BITS-1:0] cluster_color;
  logic signed [COORD_BITS-1:0] centroid_x;
  logic signed [COORD_BITS-1:0] centroid_y;
  logic signed [COORD_BITS-1:0] centroid_z;
  logic [COUNT_BITS-1:0] member_count;
  logic no_cluster;
  logic [DROP_BITS-1:0] dropped_points;
  logic last_record;

  modport source(output valid, cluster_color, centroid_x, centroid_y, centroid_z,
                 member_count, no_cluster, dropped_points, last_record,
                 input ready);
  modport sink(input valid, cluster_color, centroid_x, centroid_y, centroid_z,
               member_count, no_cluster, dropped_points, last_record,
               output ready);
endinterface

// ----- hdl/plc_cfg_if.sv -----
interface plc_cfg_if import plc_pkg::*;;
  logic valid;
  logic ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/plc_ram.sv -----
module plc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/plc_div.sv -----
module plc_div import plc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [COORD_BITS+17:0]  num,
  input  logic [DEN_BITS-1:0]            den,
  output logic                           done,
  output logic signed [COORD_BITS-1:0]   quot
);

  localparam int NW = COORD_BITS + 18;
  localparam int CW = $clog2(COORD_BITS + 1);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [DEN_BITS-1:0]   rem;
  logic [DEN_BITS-1:0]   dreg;
  logic [COORD_BITS-1:0] sh;
  logic                  neg;

  logic signed [NW:0] num_ext;
  logic [NW:0]        mag;
  logic [NW:0]        biased;
  logic [DEN_BITS:0]  trial;
  logic               ge;
  logic [DEN_BITS:0]  diff;

  // Rounding to nearest, ties away from zero: add half the divisor to the magnitude.
  assign num_ext = {num[NW-1], num};
  assign mag = num_ext[NW] ? (NW+1)'(-num_ext) : num_ext;
  assign biased = mag + (NW+1)'(den >> 1);

  assign trial = {rem, sh[COORD_BITS-1]};
  assign ge = trial >= {1'b0, dreg};
  assign diff = trial - {1'b0, dreg};
  assign quot = neg ? -$signed(sh) : $signed(sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(COORD_BITS);
        neg <= num[NW-1];
        dreg <= den;
        rem <= biased[COORD_BITS+DEN_BITS-1:COORD_BITS];
        sh <= biased[COORD_BITS-1:0];
      end else if (busy) begin
        rem <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        sh <= {sh[COORD_BITS-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/point_leader_clustering_core.sv -----
// Leader clustering of color-labelled 3D points.
// Points arrive on the pt channel, one beat per point; rec carries cluster records;
// cfg writes the join radius (index 0) and the minimum cluster size (index 1) and
// is always ready. Configuration is to be written while the block is idle; the
// block itself does not enforce this. A point is taken only while the sequencer is
// idle. A point whose color table is empty goes straight to the insert step. A
// search reads one table entry per visited cluster, newest first, through the
// single read port of the table RAM and the one shared multiplier: a read wait,
// the squares of dx, dy and dz, and a compare with the squared radius. A miss then
// opens a cluster or drops the point. A join multiplies each centroid coordinate by
// the member count and divides by the count plus one in three dividers that run
// side by side. On frame end each color is scanned in turn, each stored cluster is
// read and checked, and qualifying clusters are sent newest first. One record is
// held back so the last one can be marked; the final beat follows the scan.
// If the receiver stalls, the record register holds and the scan waits.
// Reset clears occupancy, drop counter, held record and output valid; table
// contents need no clearing since only occupied entries are ever read.
module point_leader_clustering_core import plc_pkg::*; #(
  parameter int COLOR_COUNT = 6,
  parameter int CLUSTERS_PER_COLOR = 8,
  parameter int COORD_BITS = 16
) (
  input logic clk,
  input logic rst,
  plc_point_if.sink pt,
  plc_record_if.source rec,
  plc_cfg_if.sink cfg
);

  localparam int CB = COORD_BITS;
  localparam int SB = (CLUSTERS_PER_COLOR > 1) ? $clog2(CLUSTERS_PER_COLOR) : 1;
  localparam int CLB = (COLOR_COUNT > 1) ? $clog2(COLOR_COUNT) : 1;
  localparam int AB = CLB + SB;
  localparam int DEPTH = COLOR_COUNT * (2 ** SB);
  localparam int EW = 3 * CB + COUNT_BITS;
  localparam int OW = $clog2(CLUSTERS_PER_COLOR + 1);
  localparam int MW = (CB + 2 > 18) ? CB + 2 : 18;
  localparam int NW = CB + 18;
  localparam int AW = 2 * CB + 2;
  localparam int LW = (AW > LIM_BITS) ? AW : LIM_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_WAIT, S_DX, S_DY, S_DZ, S_CMP, S_MX, S_MY, S_MZ, S_MW, S_DIV,
    S_NEW, S_ECOL, S_EWAIT, S_ECHK, S_EFIN
  } state_t;

  state_t state;

  logic [CFG_DATA_BITS-1:0] radius;
  logic [CFG_DATA_BITS-1:0] min_size;
  logic [OW-1:0]            occ [COLOR_COUNT];
  logic [DROP_BITS-1:0]     drop_cnt;

  // Current point.
  logic [CLB-1:0]        col;
  logic signed [CB-1:0]  px, py, pz;
  logic                  fend;
  logic [SB-1:0]         slot;
  logic [CLB:0]          ec;

  // Table RAM.
  logic          wr_en;
  logic [AB-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [AB-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  logic signed [CB-1:0]   cur_cx, cur_cy, cur_cz;
  logic [COUNT_BITS-1:0]  cur_n;

  // Shared multiplier.
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] prod;
  logic [AW-1:0]          acc;
  logic [AW-1:0]          dist_sum;
  logic [LIM_BITS-1:0]    lim;
  logic [10:0]            rad_mm;
  logic signed [CB:0]     dx, dy, dz;

  logic signed [NW-1:0] num_x, num_y, num_z_c;
  logic [DEN_BITS-1:0]  den;
  logic                 div_start;
  logic                 div_done, div_done_y, div_done_z;
  logic signed [CB-1:0] q_x, q_y, q_z;

  // Held record during the frame-end scan.
  logic                  have_hold;
  logic [COLOR_BITS-1:0] hold_color;
  logic signed [CB-1:0]  hold_cx, hold_cy, hold_cz;
  logic [COUNT_BITS-1:0] hold_n;

  logic                 rec_valid;
  logic                 rec_load;
  logic                 out_free;
  logic                 pt_ok;
  logic [CLB-1:0]       pt_col;
  logic [COUNT_BITS-1:0] n_inc;

  assign cfg.ready = 1'b1;
  assign pt.ready = (state == S_IDLE);
  assign rec.valid = rec_valid;
  assign out_free = !rec_valid || rec.ready;

  // A record register is loaded when a held cluster is pushed out by a newer one,
  // or when the closing beat of the frame goes out.
  assign rec_load = (state == S_ECHK && cur_n >= COUNT_BITS'(min_size) && have_hold &&
                     out_free) || (state == S_EFIN && out_free);

  assign pt_col = pt.color_class[CLB-1:0];
  assign pt_ok = pt.point_valid && ({1'b0, pt.color_class} < 4'(COLOR_COUNT));

  assign {cur_cx, cur_cy, cur_cz, cur_n} = rd_data;
  assign n_inc = (cur_n == COUNT_MAX) ? cur_n : cur_n + 1'b1;
  assign den = DEN_BITS'(cur_n) + 1'b1;

  assign dx = $signed({px[CB-1], px}) - $signed({cur_cx[CB-1], cur_cx});
  assign dy = $signed({py[CB-1], py}) - $signed({cur_cy[CB-1], cur_cy});
  assign dz = $signed({pz[CB-1], pz}) - $signed({cur_cz[CB-1], cur_cz});

  assign rad_mm = 11'(radius) * 11'(CM_TO_MM);
  assign lim = LIM_BITS'(rad_mm) * LIM_BITS'(rad_mm);
  assign dist_sum = acc + prod[AW-1:0];

  assign num_z_c = prod[NW-1:0] + NW'(pz);
  assign div_start = (state == S_MW);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DX: begin mul_a = MW'(dx); mul_b = MW'(dx); end
      S_DY: begin mul_a = MW'(dy); mul_b = MW'(dy); end
      S_DZ: begin mul_a = MW'(dz); mul_b = MW'(dz); end
      S_MX: begin mul_a = MW'(cur_cx); mul_b = $signed(MW'(cur_n)); end
      S_MY: begin mul_a = MW'(cur_cy); mul_b = $signed(MW'(cur_n)); end
      S_MZ: begin mul_a = MW'(cur_cz); mul_b = $signed(MW'(cur_n)); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Table writes: a fresh cluster, or the blended centroid after a join.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = {col, slot};
    wr_data = {cur_cx, cur_cy, cur_cz, n_inc};
    if (state == S_NEW && occ[col] < OW'(CLUSTERS_PER_COLOR)) begin
      wr_en = 1'b1;
      wr_addr = {col, occ[col][SB-1:0]};
      wr_data = {px, py, pz, COUNT_BITS'(1)};
    end else if (state == S_DIV && div_done) begin
      wr_en = 1'b1;
      wr_data = {q_x, q_y, q_z, n_inc};
    end
  end

  plc_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_table (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  plc_div #(.COORD_BITS(CB)) u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .num(num_x), .den(den),
    .done(div_done), .quot(q_x)
  );
  plc_div #(.COORD_BITS(CB)) u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .num(num_y), .den(den),
    .done(div_done_y), .quot(q_y)
  );
  plc_div #(.COORD_BITS(CB)) u_div_z (
    .clk(clk), .rst(rst), .start(div_start), .num(num_z_c), .den(den),
    .done(div_done_z), .quot(q_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      radius <= RADIUS_RESET;
      min_size <= MIN_SIZE_RESET;
      for (int i = 0; i < COLOR_COUNT; i++) begin
        occ[i] <= '0;
      end
      drop_cnt <= '0;
      have_hold <= 1'b0;
      rec_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_MATCH_RADIUS: radius <= cfg.data;
          CFG_MIN_SIZE:     min_size <= cfg.data;
          default: ;
        endcase
      end
      if (rec_load) begin
        rec_valid <= 1'b1;
      end else if (rec_valid && rec.ready) begin
        rec_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (pt.valid) begin
            col <= pt_col;
            px <= pt.pos_x;
            py <= pt.pos_y;
            pz <= pt.pos_z;
            fend <= pt.frame_end;
            ec <= '0;
            if (pt_ok && occ[pt_col] != '0) begin
              slot <= SB'(occ[pt_col] - 1'b1);
              rd_addr <= {pt_col, SB'(occ[pt_col] - 1'b1)};
              state <= S_WAIT;
            end else if (pt_ok) begin
              state <= S_NEW;
            end else if (pt.frame_end) begin
              state <= S_ECOL;
            end
          end
        end
        S_WAIT: state <= S_DX;
        S_DX: state <= S_DY;
        S_DY: begin
          acc <= prod[AW-1:0];
          state <= S_DZ;
        end
        S_DZ: begin
          acc <= dist_sum;
          state <= S_CMP;
        end
        S_CMP: begin
          if (LW'(dist_sum) < LW'(lim)) begin
            state <= S_MX;
          end else if (slot == '0) begin
            state <= S_NEW;
          end else begin
            slot <= slot - 1'b1;
            rd_addr <= {col, slot - 1'b1};
            state <= S_WAIT;
          end
        end
        S_MX: state <= S_MY;
        S_MY: begin
          num_x <= prod[NW-1:0] + NW'(px);
          state <= S_MZ;
        end
        S_MZ: begin
          num_y <= prod[NW-1:0] + NW'(py);
          state <= S_MW;
        end
        S_MW: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= fend ? S_ECOL : S_IDLE;
          end
        end
        S_NEW: begin
          if (occ[col] < OW'(CLUSTERS_PER_COLOR)) begin
            occ[col] <= occ[col] + 1'b1;
          end else if (drop_cnt != DROP_MAX) begin
            drop_cnt <= drop_cnt + 1'b1;
          end
          state <= fend ? S_ECOL : S_IDLE;
        end
        S_ECOL: begin
          if (ec == (CLB+1)'(COLOR_COUNT)) begin
            state <= S_EFIN;
          end else if (occ[ec[CLB-1:0]] == '0) begin
            ec <= ec + 1'b1;
          end else begin
            slot <= SB'(occ[ec[CLB-1:0]] - 1'b1);
            rd_addr <= {ec[CLB-1:0], SB'(occ[ec[CLB-1:0]] - 1'b1)};
            state <= S_EWAIT;
          end
        end
        S_EWAIT: state <= S_ECHK;
        S_ECHK: begin
          // A qualifying cluster replaces the held one, which goes out first.
          if (cur_n < COUNT_BITS'(min_size) || !have_hold || out_free) begin
            if (cur_n >= COUNT_BITS'(min_size)) begin
              if (have_hold) begin
                rec.cluster_color <= hold_color;
                rec.centroid_x <= hold_cx;
                rec.centroid_y <= hold_cy;
                rec.centroid_z <= hold_cz;
                rec.member_count <= hold_n;
                rec.no_cluster <= 1'b0;
                rec.dropped_points <= drop_cnt;
                rec.last_record <= 1'b0;
              end
              have_hold <= 1'b1;
              hold_color <= COLOR_BITS'(ec);
              hold_cx <= cur_cx;
              hold_cy <= cur_cy;
              hold_cz <= cur_cz;
              hold_n <= cur_n;
            end
            if (slot == '0) begin
              ec <= ec + 1'b1;
              state <= S_ECOL;
            end else begin
              slot <= slot - 1'b1;
              rd_addr <= {ec[CLB-1:0], slot - 1'b1};
              state <= S_EWAIT;
            end
          end
        end
        S_EFIN: begin
          if (out_free) begin
            rec.cluster_color <= have_hold ? hold_color : '0;
            rec.centroid_x <= have_hold ? hold_cx : '0;
            rec.centroid_y <= have_hold ? hold_cy : '0;
            rec.centroid_z <= have_hold ? hold_cz : '0;
            rec.member_count <= have_hold ? hold_n : '0;
            rec.no_cluster <= !have_hold;
            rec.dropped_points <= drop_cnt;
            rec.last_record <= 1'b1;
            have_hold <= 1'b0;
            drop_cnt <= '0;
            for (int i = 0; i < COLOR_COUNT; i++) begin
              occ[i] <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The table is written only when a cluster is opened or a join completes.
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_NEW || state == S_DIV))
    else $error("table write outside insert or join");

  // The three dividers run in lock step and finish only while a join waits.
  a_div_sync: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_done_y && div_done_z && state == S_DIV))
    else $error("divider completion out of step");

  // Closing a frame leaves the drop counter and held record cleared.
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_EFIN && out_free) |=> (drop_cnt == '0 && !have_hold && state == S_IDLE))
    else $error("frame state not cleared after last record");

endmodule
